@@ sv/priority_schedule_wait_times_unit_defines.svh @@
// Assertion macros shared by the checker of the priority scheduling unit.
// Depends on nothing; the including scope must provide aclk and aresetn.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_UNIT_DEFINES_SVH

// A property checked at every rising edge outside reset.
`define PSW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("psw assertion failed");

// A condition whose consequence must hold in the cycle after it.
`define PSW_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error("psw assertion failed");

`endif

@@ sv/psw_pkg.sv @@
// Shared types, widths and helpers of the priority scheduling unit.
// Depends on nothing; used by the cell, the output stage and the top level.
package psw_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int BURST_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int IDX_W         = 4;
    localparam int TIME_W        = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [IDX_W-1:0]   idx;
    } job_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [BURST_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - BURST_W){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

@@ sv/psw_cell.sv @@
// One cell of the sorted job chain: holds one job and its valid bit.
// Depends on psw_pkg.
module psw_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  psw_pkg::cell_ctrl_t ctrl,
    input  psw_pkg::job_t       new_job,
    input  psw_pkg::job_t       left_job,
    input  logic                left_valid,
    input  logic                left_disp,
    input  psw_pkg::job_t       right_job,
    input  logic                right_valid,
    output psw_pkg::job_t       job,
    output logic                valid,
    output logic                disp
);
    import psw_pkg::*;

    job_t job_reg, job_next;
    logic valid_reg, valid_next;

    // Strictly greater keeps equal priorities in arrival order.
    assign disp = !valid_reg || (job_reg.prio > new_job.prio);

    always_comb begin
        job_next   = job_reg;
        valid_next = valid_reg;
        if (ctrl.ins && disp) begin
            if (left_disp) begin
                job_next   = left_job;
                valid_next = left_valid;
            end else begin
                job_next   = new_job;
                valid_next = 1'b1;
            end
        end else if (ctrl.shift) begin
            job_next   = right_job;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        job_reg <= job_next;
    end

    assign job   = job_reg;
    assign valid = valid_reg;

endmodule

@@ sv/psw_out.sv @@
// Output stage: accumulates waiting time and holds the result beat.
// Depends on psw_pkg.
module psw_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop,
    input  psw_pkg::job_t          head_job,
    input  logic                   head_last,
    input  logic                   set_ovf,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [71:0]            m_axis_tdata,  // job_index, job_burst, job_prio,
                                                  // wait_time, turnaround, zero pad
    output logic                   m_axis_tuser,  // overflow
    output logic                   m_axis_tlast   // last_result
);
    import psw_pkg::*;

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] acc_reg, acc_next;
    logic [TIME_W-1:0] wait_reg, turn_reg;
    logic [TIME_W-1:0] turn_calc;
    job_t              job_reg;
    logic              ovf_reg, last_reg;

    assign turn_calc = sat_add(acc_reg, head_job.burst);

    always_comb begin
        valid_next = valid_reg;
        acc_next   = acc_reg;
        if (pop) begin
            valid_next = 1'b1;
            acc_next   = head_last ? '0 : turn_calc;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
        end
        if (pop) begin
            job_reg  <= head_job;
            wait_reg <= acc_reg;
            turn_reg <= turn_calc;
            ovf_reg  <= set_ovf;
            last_reg <= head_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0, turn_reg, wait_reg, job_reg.prio, job_reg.burst, job_reg.idx};
    assign m_axis_tuser  = ovf_reg;
    assign m_axis_tlast  = last_reg;

endmodule

@@ sv/priority_schedule_wait_times_unit.sv @@
// Top level of the nonpreemptive priority scheduling unit.
// Depends on psw_pkg, psw_cell and psw_out.
//
//  channel   direction  tdata                     tuser     tlast
//  s_axis    in         burst, prio               -         last_job
//  m_axis    out        index, burst, prio,       overflow  last_result
//                       wait, turnaround
//
// Each job that fits is inserted into the sorted cell chain, one job per cycle while
// s_axis_tready is high. After the final job, the chain shifts out one result per
// cycle into the output register while that register is free; s_axis_tready is low
// from the final job until the last result has left the chain.
// A stalled m_axis holds the chain; reset clears the valid bits, count and flags.
module priority_schedule_wait_times_unit #(
    parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // burst, prio
    input  logic        s_axis_tlast,   // last_job
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // job_index, job_burst, job_prio,
                                        // wait_time, turnaround, zero pad
    output logic        m_axis_tuser,   // overflow
    output logic        m_axis_tlast    // last_result
);
    import psw_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             set_ovf_reg, set_ovf_next;
    logic             drain_reg, drain_next;

    logic             s_hs, full, pop, head_last;
    logic [CNT_W+3:0] count_ext;
    job_t             new_job;
    cell_ctrl_t       ctrl;

    job_t             cell_job   [MAX_PROCS];
    logic             cell_valid [MAX_PROCS];
    logic             cell_disp  [MAX_PROCS];

    assign s_axis_tready = !drain_reg;
    assign s_hs          = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CNT_W'(MAX_PROCS));
    assign count_ext     = {4'b0, count_reg};

    assign new_job.burst = s_axis_tdata[15:0];
    assign new_job.prio  = s_axis_tdata[23:16];
    assign new_job.idx   = count_ext[3:0];

    assign pop       = drain_reg && cell_valid[0] && (!m_axis_tvalid || m_axis_tready);
    assign head_last = !cell_valid[1];

    assign ctrl.ins   = s_hs && !full;
    assign ctrl.shift = pop;

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        job_t lj, rj;
        logic lv, ld, rv;
        if (i == 0) begin : g_first
            assign lj = '0;
            assign lv = 1'b0;
            assign ld = 1'b0;
        end else begin : g_mid
            assign lj = cell_job[i-1];
            assign lv = cell_valid[i-1];
            assign ld = cell_disp[i-1];
        end
        if (i == MAX_PROCS - 1) begin : g_end
            assign rj = '0;
            assign rv = 1'b0;
        end else begin : g_inner
            assign rj = cell_job[i+1];
            assign rv = cell_valid[i+1];
        end
        psw_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_job     (new_job),
            .left_job    (lj),
            .left_valid  (lv),
            .left_disp   (ld),
            .right_job   (rj),
            .right_valid (rv),
            .job         (cell_job[i]),
            .valid       (cell_valid[i]),
            .disp        (cell_disp[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        set_ovf_next = set_ovf_reg;
        drain_next   = drain_reg;
        if (s_hs) begin
            if (s_axis_tlast) begin
                count_next   = '0;
                ovf_next     = 1'b0;
                set_ovf_next = ovf_reg || full;
                drain_next   = 1'b1;
            end else if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
        end else if (pop && head_last) begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            set_ovf_reg <= 1'b0;
            drain_reg   <= 1'b0;
        end else begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            set_ovf_reg <= set_ovf_next;
            drain_reg   <= drain_next;
        end
    end

    psw_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop           (pop),
        .head_job      (cell_job[0]),
        .head_last     (head_last),
        .set_ovf       (set_ovf_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ sv/psw_checker.sv @@
// Port-level checks of the priority scheduling unit, bound to the top level.
// Depends on priority_schedule_wait_times_unit_defines.svh.
`include "priority_schedule_wait_times_unit_defines.svh"

module psw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    logic [20:0] sum;
    logic        s_hs, m_hs;

    assign sum  = {1'b0, m_axis_tdata[47:28]} + {5'b0, m_axis_tdata[19:4]};
    assign s_hs = s_axis_tvalid && s_axis_tready;
    assign m_hs = m_axis_tvalid && m_axis_tready;

    // A stalled result beat keeps its contents.
    `PSW_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                     && $stable(m_axis_tuser))
    // Turnaround is wait plus burst unless the sum has saturated.
    `PSW_ASSERT(a_turn, m_axis_tvalid && !sum[20] |-> m_axis_tdata[67:48] == sum[19:0])
    // The final job closes the input until its set has drained.
    `PSW_ASSERT_NEXT(a_close, s_hs && s_axis_tlast, !s_axis_tready)
    // Within a set, each wait time continues from the previous turnaround.
    `PSW_ASSERT_NEXT(a_chain, m_hs && !m_axis_tlast,
                     m_axis_tvalid && m_axis_tdata[47:28] == $past(m_axis_tdata[67:48]))

endmodule

bind priority_schedule_wait_times_unit psw_checker u_psw_checker (.*);
